>>> design/cham_pkg.sv
// Shared types, constants and a rotate helper for the CHAM-128/128 encryption core.
package cham_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 4;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned ROUND_W     = $clog2(ROUNDS);
  localparam int unsigned RK_IDX_W    = 3;
  localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);
  localparam int unsigned CFG_IDX_W   = 8;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [ROUND_W-1:0]   round_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam round_t LAST_ROUND = round_t'(ROUNDS - 1);

  // Configuration register map
  localparam cfg_idx_t REG_KEY_WORD0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_KEY_WORD1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_KEY_WORD2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_KEY_WORD3 = cfg_idx_t'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Controller to datapath / key unit
  typedef struct packed {
    logic   load_in;         // capture plaintext into the round state
    logic   step;            // apply one round
    logic   out_load;        // fill the output register
    logic   out_from_round;  // take the output from this cycle's round result
    round_t round;           // current round number
  } ctrl_cmd_t;

  function automatic word_t rol(input word_t v, input int unsigned n);
    return word_t'((v << n) | (v >> (WORD_W - n)));
  endfunction

endpackage

>>> design/cham_if.sv
// Valid/ready channel interfaces for plaintext, ciphertext and key writes.
interface cham_in_if;
  logic           valid;
  logic           ready;
  cham_pkg::word_t plain_word0;
  cham_pkg::word_t plain_word1;
  cham_pkg::word_t plain_word2;
  cham_pkg::word_t plain_word3;

  modport source (output valid, plain_word0, plain_word1, plain_word2, plain_word3,
                  input ready);
  modport sink   (input valid, plain_word0, plain_word1, plain_word2, plain_word3,
                  output ready);
endinterface

interface cham_out_if;
  logic           valid;
  logic           ready;
  cham_pkg::word_t cipher_word0;
  cham_pkg::word_t cipher_word1;
  cham_pkg::word_t cipher_word2;
  cham_pkg::word_t cipher_word3;

  modport source (output valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
                  input ready);
  modport sink   (input valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
                  output ready);
endinterface

interface cham_cfg_if;
  logic               valid;
  logic               ready;
  cham_pkg::cfg_idx_t index;
  cham_pkg::word_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/cham_key.sv
// Key registers and per-round key derivation.
module cham_key (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  cham_pkg::cfg_idx_t wr_index,
  input  cham_pkg::word_t    wr_data,
  input  cham_pkg::round_t   round,
  output cham_pkg::word_t    rk
);

  cham_pkg::word_t key_r   [cham_pkg::KEY_WORDS];
  cham_pkg::word_t key_nxt [cham_pkg::KEY_WORDS];

  logic [cham_pkg::RK_IDX_W-1:0]  rk_idx;
  logic [cham_pkg::KEY_IDX_W-1:0] key_sel;
  cham_pkg::word_t                k;

  always_comb begin
    for (int j = 0; j < cham_pkg::KEY_WORDS; j++) begin
      key_nxt[j] = key_r[j];
    end
    if (wr_en) begin
      case (wr_index)
        cham_pkg::REG_KEY_WORD0: key_nxt[0] = wr_data;
        cham_pkg::REG_KEY_WORD1: key_nxt[1] = wr_data;
        cham_pkg::REG_KEY_WORD2: key_nxt[2] = wr_data;
        cham_pkg::REG_KEY_WORD3: key_nxt[3] = wr_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < cham_pkg::KEY_WORDS; j++) begin
      if (!rst_n) begin
        key_r[j] <= '0;
      end else begin
        key_r[j] <= key_nxt[j];
      end
    end
  end

  // rk[0..3] use rol8 of key word j; rk[4..7] use rol11 of key word (idx^1)&3
  assign rk_idx  = round[cham_pkg::RK_IDX_W-1:0];
  assign key_sel = rk_idx[2] ? (rk_idx[1:0] ^ 2'b01) : rk_idx[1:0];
  assign k       = key_r[key_sel];

  always_comb begin
    if (rk_idx[2]) begin
      rk = k ^ cham_pkg::rol(k, 1) ^ cham_pkg::rol(k, 11);
    end else begin
      rk = k ^ cham_pkg::rol(k, 1) ^ cham_pkg::rol(k, 8);
    end
  end

endmodule

>>> design/cham_dp.sv
// Round datapath: four-word state, one round per cycle, output register.
module cham_dp (
  input  logic                clk,
  input  cham_pkg::ctrl_cmd_t cmd,
  input  cham_pkg::word_t     plain  [cham_pkg::BLOCK_WORDS],
  input  cham_pkg::word_t     rk,
  output cham_pkg::word_t     cipher [cham_pkg::BLOCK_WORDS]
);

  cham_pkg::word_t x_r     [cham_pkg::BLOCK_WORDS];
  cham_pkg::word_t x_nxt   [cham_pkg::BLOCK_WORDS];
  cham_pkg::word_t out_r   [cham_pkg::BLOCK_WORDS];
  cham_pkg::word_t out_nxt [cham_pkg::BLOCK_WORDS];
  cham_pkg::word_t shifted [cham_pkg::BLOCK_WORDS];

  logic            odd;
  cham_pkg::word_t mixed;
  cham_pkg::word_t sum;
  cham_pkg::word_t nw;

  assign odd   = cmd.round[0];
  assign mixed = (odd ? cham_pkg::rol(x_r[1], 8) : cham_pkg::rol(x_r[1], 1)) ^ rk;
  assign sum   = (x_r[0] ^ cham_pkg::word_t'(cmd.round)) + mixed;
  assign nw    = odd ? cham_pkg::rol(sum, 1) : cham_pkg::rol(sum, 8);

  assign shifted[0] = x_r[1];
  assign shifted[1] = x_r[2];
  assign shifted[2] = x_r[3];
  assign shifted[3] = nw;

  always_comb begin
    for (int j = 0; j < cham_pkg::BLOCK_WORDS; j++) begin
      if (cmd.load_in) begin
        x_nxt[j] = plain[j];
      end else if (cmd.step) begin
        x_nxt[j] = shifted[j];
      end else begin
        x_nxt[j] = x_r[j];
      end
      if (cmd.out_load) begin
        out_nxt[j] = cmd.out_from_round ? shifted[j] : x_r[j];
      end else begin
        out_nxt[j] = out_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < cham_pkg::BLOCK_WORDS; j++) begin
      x_r[j]   <= x_nxt[j];
      out_r[j] <= out_nxt[j];
    end
  end

  assign cipher = out_r;

endmodule

>>> design/cham_ctrl.sv
// Controller: round sequencing and input/output handshake.
module cham_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output cham_pkg::ctrl_cmd_t cmd
);

  cham_pkg::state_t state_r, state_nxt;
  cham_pkg::round_t round_r, round_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last;
  logic             out_free;
  logic             accept;

  assign last     = (round_r == cham_pkg::LAST_ROUND);
  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_ready && in_valid;

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.round = round_r;
    case (state_r)
      cham_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      cham_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (last && out_free) begin
          cmd.out_load       = 1'b1;
          cmd.out_from_round = 1'b1;
          in_ready           = 1'b1;
        end
      end
      cham_pkg::ST_HOLD: begin
        if (out_ready) begin
          cmd.out_load = 1'b1;
          in_ready     = 1'b1;
        end
      end
      default: ;
    endcase
    cmd.load_in = in_ready && in_valid;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cham_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cham_pkg::ST_RUN;
        end
      end
      cham_pkg::ST_RUN: begin
        if (last) begin
          if (!out_free) begin
            state_nxt = cham_pkg::ST_HOLD;
          end else if (in_valid) begin
            state_nxt = cham_pkg::ST_RUN;
          end else begin
            state_nxt = cham_pkg::ST_IDLE;
          end
        end
      end
      cham_pkg::ST_HOLD: begin
        if (out_ready) begin
          state_nxt = in_valid ? cham_pkg::ST_RUN : cham_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cham_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (accept) begin
      round_nxt = '0;
    end else if (state_r == cham_pkg::ST_RUN && !last) begin
      round_nxt = round_r + cham_pkg::round_t'(1);
    end else begin
      round_nxt = round_r;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cham_pkg::ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/cham128_block_encrypt.sv
// Top level of the CHAM-128/128 block encryption core.
// One 128-bit block goes in on in_ch as four 32-bit words (word 0 first) and the
// ciphertext comes out on out_ch in the same word order; every item in gives
// exactly one item out. The 128-bit key lives in four registers written over
// cfg_ch (index 0..3 = key words 0..3, other indexes ignored, all reset to 0);
// cfg_ch is always ready, and the key should only be changed while no block is
// in flight. A single round unit is iterated, one round per clock, and the
// last round's result goes into the output register. The next
// block is accepted on the same edge the previous result is loaded, so the
// core takes no new block while one is still in its rounds. The output
// register decouples the two sides: if the ciphertext is not taken, the core
// still finishes the block in hand and only then waits, holding in_ch.ready
// low until the output frees. Round keys are formed on the fly from the key
// registers each cycle.
module cham128_block_encrypt (
  input  logic    clk,
  input  logic    rst_n,
  cham_in_if.sink    in_ch,
  cham_out_if.source out_ch,
  cham_cfg_if.sink   cfg_ch
);

  cham_pkg::ctrl_cmd_t cmd;
  cham_pkg::word_t     rk;
  cham_pkg::word_t     plain  [cham_pkg::BLOCK_WORDS];
  cham_pkg::word_t     cipher [cham_pkg::BLOCK_WORDS];

  // key writes never stall
  assign cfg_ch.ready = 1'b1;

  assign plain[0] = in_ch.plain_word0;
  assign plain[1] = in_ch.plain_word1;
  assign plain[2] = in_ch.plain_word2;
  assign plain[3] = in_ch.plain_word3;

  cham_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  cham_key u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .round    (cmd.round),
    .rk       (rk)
  );

  cham_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .plain  (plain),
    .rk     (rk),
    .cipher (cipher)
  );

  // ciphertext straight from the output register
  assign out_ch.cipher_word0 = cipher[0];
  assign out_ch.cipher_word1 = cipher[1];
  assign out_ch.cipher_word2 = cipher[2];
  assign out_ch.cipher_word3 = cipher[3];

endmodule

>>> design/cham_chk.sv
// Port-level assertions for the CHAM-128/128 core, bound to the top level.
module cham_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input cham_pkg::word_t cipher_word0,
  input cham_pkg::word_t cipher_word1,
  input cham_pkg::word_t cipher_word2,
  input cham_pkg::word_t cipher_word3
);

  // a block occupies the round unit, so no item is taken the very next cycle
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // once the accepted block's rounds are done, out_valid is high
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##81 out_valid)
    else $error("ciphertext not ready after 80 rounds");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(cipher_word0) && $stable(cipher_word1)
      && $stable(cipher_word2) && $stable(cipher_word3))
    else $error("output payload changed while stalled");

endmodule

bind cham128_block_encrypt cham_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cipher_word0 (out_ch.cipher_word0),
  .cipher_word1 (out_ch.cipher_word1),
  .cipher_word2 (out_ch.cipher_word2),
  .cipher_word3 (out_ch.cipher_word3)
);

>>> tb/cham128_block_encrypt_tb.sv
// Self-checking testbench for the CHAM-128/128 block encryption core.
module cham128_block_encrypt_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Four words of one block or key, word 0 in slice [0]
  typedef logic [cham_pkg::BLOCK_WORDS-1:0][cham_pkg::WORD_W-1:0] block_t;

  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES  = 100;   // a block's latency plus margin
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned PHASE_BLOCKS   = 150;

  // Indexes outside the key map; writes to them must leave the key alone
  localparam cham_pkg::cfg_idx_t IDX_UNMAPPED = cham_pkg::cfg_idx_t'(4);
  localparam cham_pkg::cfg_idx_t IDX_TOP      = '1;

  logic clk = 1'b0;
  logic rst_n;

  cham_in_if  in_ch();
  cham_out_if out_ch();
  cham_cfg_if cfg_ch();

  cham128_block_encrypt i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Key as the core should hold it, and ciphertexts still to come out
  block_t      key_q;
  block_t      cipher_q [$];

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  int unsigned blocks_sent    = 0;
  int unsigned blocks_checked = 0;
  int unsigned key_settings   = 0;
  int unsigned mismatch_cnt   = 0;

  function automatic cham_pkg::word_t rotl32(input cham_pkg::word_t v, input int unsigned n);
    logic [2*cham_pkg::WORD_W-1:0] dbl;
    dbl = {v, v} << n;
    return dbl[2*cham_pkg::WORD_W-1:cham_pkg::WORD_W];
  endfunction

  // Full 80-round encryption with round keys formed from the current key
  function automatic block_t cham_encrypt(input block_t key, input block_t pt);
    cham_pkg::word_t rk [8];
    cham_pkg::word_t x0, x1, x2, x3, mix, nw, base;
    for (int j = 0; j < 4; j++) begin
      base            = key[j] ^ rotl32(key[j], 1);
      rk[j]           = base ^ rotl32(key[j], 8);
      rk[(j + 4) ^ 1] = base ^ rotl32(key[j], 11);
    end
    x0 = pt[0];
    x1 = pt[1];
    x2 = pt[2];
    x3 = pt[3];
    for (int r = 0; r < cham_pkg::ROUNDS; r++) begin
      if (r % 2 == 0) begin
        mix = rotl32(x1, 1) ^ rk[r & 7];
        nw  = rotl32((x0 ^ cham_pkg::word_t'(r)) + mix, 8);
      end else begin
        mix = rotl32(x1, 8) ^ rk[r & 7];
        nw  = rotl32((x0 ^ cham_pkg::word_t'(r)) + mix, 1);
      end
      x0 = x1;
      x1 = x2;
      x2 = x3;
      x3 = nw;
    end
    return {x3, x2, x1, x0};
  endfunction

  function automatic block_t rand_block();
    block_t b;
    for (int w = 0; w < 4; w++) begin
      // corner words now and then so carries run the full width
      case ($urandom_range(0, 9))
        0:       b[w] = '0;
        1:       b[w] = '1;
        default: b[w] = $urandom;
      endcase
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;                       // ready already low
      end else if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready <= 1'b0;
        stall_left   = HOLD_CYCLES - 1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left   = $urandom_range(1, 4) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted ciphertext against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    block_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.cipher_word3, out_ch.cipher_word2,
             out_ch.cipher_word1, out_ch.cipher_word0};
      if (cipher_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: expected no ciphertext, actual %h", $time, got);
      end else begin
        want = cipher_q.pop_front();
        blocks_checked++;
        for (int w = 0; w < 4; w++) begin
          if (got[w] !== want[w]) begin
            mismatch_cnt++;
            $display("%0t: cipher_word%0d expected %h actual %h",
                     $time, w, want[w], got[w]);
          end
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the core has hung
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one plaintext item, optionally after a short gap; valid stays high
  // on return so back-to-back items never drop it within one step.
  task automatic send_block(input block_t pt);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.plain_word0 <= pt[0];
    in_ch.plain_word1 <= pt[1];
    in_ch.plain_word2 <= pt[2];
    in_ch.plain_word3 <= pt[3];
    do @(posedge clk); while (!in_ch.ready);
    cipher_q.push_back(cham_encrypt(key_q, pt));
    blocks_sent++;
  endtask

  // Drop valid, then wait for every outstanding ciphertext
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cham_pkg::cfg_idx_t idx, input cham_pkg::word_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx <= cham_pkg::REG_KEY_WORD3)
      key_q[idx[1:0]] = data;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_key(input block_t key);
    // order shuffled a little so no write sequence is assumed
    cfg_write(cham_pkg::REG_KEY_WORD2, key[2]);
    cfg_write(cham_pkg::REG_KEY_WORD0, key[0]);
    cfg_write(cham_pkg::REG_KEY_WORD3, key[3]);
    cfg_write(cham_pkg::REG_KEY_WORD1, key[1]);
    key_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Key left at its reset value of zero; plaintext extremes
  task automatic test_reset_key();
    key_settings++;
    send_block('0);
    send_block('1);
    send_block({4{32'h0000_0001}});
    send_block({4{32'h8000_0000}});
    send_block({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    send_block({32'hFFEE_DDCC, 32'hBBAA_9988, 32'h7766_5544, 32'h3322_1100});
    drain();
  endtask

  // Key extremes, a byte-counting key, and writes to unmapped indexes
  task automatic test_key_extremes();
    write_key('1);
    send_block('0);
    send_block('1);
    send_block({32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    drain();

    write_key({32'h0F0E_0D0C, 32'h0B0A_0908, 32'h0706_0504, 32'h0302_0100});
    send_block({32'hFFEE_DDCC, 32'hBBAA_9988, 32'h7766_5544, 32'h3322_1100});
    drain();

    write_key({32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000});
    send_block({32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001});
    send_block('1);
    drain();

    // nothing outside indexes 0..3 may reach the key
    cfg_write(IDX_UNMAPPED, 32'hDEAD_BEEF);
    cfg_write(IDX_TOP, 32'hFFFF_FFFF);
    cfg_write(cham_pkg::cfg_idx_t'($urandom_range(5, 254)), $urandom);
    send_block('0);
    send_block({32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321});
    drain();
  endtask

  // Random keys, each followed by a run of random blocks with idling both sides
  task automatic test_random_blocks();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_key(rand_block());
      repeat (PHASE_BLOCKS) send_block(rand_block());
      drain();
    end
  endtask

  // Receiver holds off while the sender keeps offering; input must back up
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (8) send_block(rand_block());
    drain();
    tx_idle_en = 1'b1;
  endtask

  // Closing stretch at full rate, no idling on either side
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_key(rand_block());
    repeat (40) send_block(rand_block());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.plain_word0 <= '0;
    in_ch.plain_word1 <= '0;
    in_ch.plain_word2 <= '0;
    in_ch.plain_word3 <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    key_q             = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_key_extremes();
    test_random_blocks();
    test_output_backpressure();
    test_full_rate();

    // anything that turns up now was never asked for
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Encrypted %0d blocks under %0d key settings, %0d ciphertexts checked,",
             blocks_sent, key_settings, blocks_checked);
    $display("with random stalls, a long output hold-off and a full-rate stretch.");
    if (mismatch_cnt == 0 && cipher_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d ciphertexts missing", mismatch_cnt, cipher_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
